// ----- rtl/core/annexb_parameter_set_extractor_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ANNEXB_PARAMETER_SET_EXTRACTOR_MACROS_SVH
`define ANNEXB_PARAMETER_SET_EXTRACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABPSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abpse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ABPSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abpse assertion failed");

`endif

// ----- rtl/core/abpse_pkg.sv -----
package abpse_pkg;

  typedef enum logic [3:0] {
    MODE_SEARCH = 4'b0001,
    MODE_SKIP   = 4'b0010,
    MODE_SPS    = 4'b0100,
    MODE_PPS    = 4'b1000
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SPS    = 2'd0,
    KIND_PPS    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // One input byte causes at most six results (final byte of a buffer).
  localparam int unsigned MaxResults = 6;
  localparam int unsigned CntW       = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      unit_kind;
    logic       unit_end;
    logic       found_both;
  } result_t;

  // Results of one input byte, in order; cnt of zero means nothing to load.
  typedef struct packed {
    logic [CntW-1:0]              cnt;
    result_t [MaxResults-1:0]     slot;
  } res_set_t;

endpackage

// ----- rtl/core/abpse_parse.sv -----
module abpse_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_data_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  logic                buf_free_i,
  output abpse_pkg::res_set_t set_o
);

  localparam logic [2:0] CodeNone  = 3'd0;
  localparam logic [2:0] CodeShort = 3'd3;
  localparam logic [2:0] CodeLong  = 3'd4;
  localparam logic [2:0] BshMax    = 3'd7;
  localparam logic [4:0] TypeSps   = 5'd7;
  localparam logic [4:0] TypePps   = 5'd8;

  typedef struct packed {
    logic [2:0]       bsh;
    logic [2:0]       hlen;
    abpse_pkg::mode_e mode;
    logic             tp;
    logic             sps;
    logic             pps;
    logic             done;
    logic             held_v;
    logic [7:0]       held_b;
  } pstate_t;

  typedef struct packed {
    pstate_t            st;
    logic               rv;
    abpse_pkg::result_t r;
  } cls_t;

  localparam pstate_t ResetState = '{
    bsh: 3'd0, hlen: 3'd0, mode: abpse_pkg::MODE_SEARCH, tp: 1'b0, sps: 1'b0,
    pps: 1'b0, done: 1'b0, held_v: 1'b0, held_b: 8'd0
  };

  // One byte position of the stream, with the start code that begins there.
  function automatic cls_t classify(pstate_t s, logic [7:0] b, logic [2:0] code);
    cls_t       o;
    logic [4:0] t;
    o.st                = s;
    o.rv                = 1'b0;
    o.r.out_byte        = s.held_b;
    o.r.unit_kind       = abpse_pkg::KIND_SPS;
    o.r.unit_end        = 1'b0;
    o.r.found_both      = 1'b0;
    t                   = b[4:0];
    if (!s.done) begin
      if (o.st.bsh != BshMax) begin
        o.st.bsh = o.st.bsh + 3'd1;
      end
      if (o.st.bsh >= o.st.hlen) begin
        if (code != CodeNone) begin
          // A new start code closes the unit being captured.
          o.rv          = s.held_v;
          o.r.unit_end  = 1'b1;
          o.r.unit_kind = (s.mode == abpse_pkg::MODE_PPS) ? abpse_pkg::KIND_PPS
                                                          : abpse_pkg::KIND_SPS;
          o.st.held_v   = 1'b0;
          if (s.sps && s.pps) begin
            o.st.done = 1'b1;
          end else begin
            o.st.mode = abpse_pkg::MODE_SKIP;
            o.st.tp   = 1'b1;
            o.st.bsh  = 3'd0;
            o.st.hlen = code;
          end
        end else if (s.mode != abpse_pkg::MODE_SEARCH) begin
          if (s.tp) begin
            o.st.tp = 1'b0;
            if (t == TypeSps && !s.sps) begin
              o.st.sps  = 1'b1;
              o.st.mode = abpse_pkg::MODE_SPS;
            end else if (t == TypePps && !s.pps) begin
              o.st.pps  = 1'b1;
              o.st.mode = abpse_pkg::MODE_PPS;
            end else begin
              o.st.mode = abpse_pkg::MODE_SKIP;
            end
          end
          if (o.st.mode == abpse_pkg::MODE_SPS || o.st.mode == abpse_pkg::MODE_PPS) begin
            // The previous byte is released now that it is known not to be the last.
            o.rv          = s.held_v;
            o.r.unit_kind = (o.st.mode == abpse_pkg::MODE_PPS) ? abpse_pkg::KIND_PPS
                                                               : abpse_pkg::KIND_SPS;
            o.st.held_b   = b;
            o.st.held_v   = 1'b1;
          end
        end
      end
    end
    return o;
  endfunction

  logic                 in_valid_q;
  logic [7:0]           in_data_q;
  logic                 in_last_q;
  pstate_t              st_q, st_d;
  logic [1:0]           wv_q, wv_d;
  logic [7:0]           win_q [3];
  logic [7:0]           win_d [3];
  logic                 fire;
  logic [2:0]           code;
  cls_t                 c [4];
  logic [5:0]           cand_v;
  abpse_pkg::result_t [5:0] cand;
  logic [abpse_pkg::CntW-1:0] n;
  pstate_t              st;

  assign fire       = in_valid_q && buf_free_i;
  assign in_ready_o = !in_valid_q || buf_free_i;

  always_comb begin
    st     = st_q;
    wv_d   = wv_q;
    win_d  = win_q;
    code   = CodeNone;
    cand_v = '0;
    cand   = '0;
    c[0]   = '0;
    c[1]   = '0;
    c[2]   = '0;
    c[3]   = '0;
    if (wv_q == 2'd3) begin
      if (win_q[0] == 8'h00 && win_q[1] == 8'h00) begin
        if (win_q[2] == 8'h00 && in_data_q == 8'h01) begin
          code = CodeLong;
        end else if (win_q[2] == 8'h01) begin
          code = CodeShort;
        end
      end
      c[0]      = classify(st, win_q[0], code);
      st        = c[0].st;
      cand_v[0] = c[0].rv;
      cand[0]   = c[0].r;
      win_d[0]  = win_q[1];
      win_d[1]  = win_q[2];
      win_d[2]  = in_data_q;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (wv_q == 2'(i)) begin
          win_d[i] = in_data_q;
        end
      end
      wv_d = wv_q + 2'd1;
    end
    if (in_last_q) begin
      // Positions left in the window cannot start a code any more.
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < wv_d) begin
          c[i+1]      = classify(st, win_d[i], CodeNone);
          st          = c[i+1].st;
          cand_v[i+1] = c[i+1].rv;
          cand[i+1]   = c[i+1].r;
        end
      end
      cand_v[4]            = st.held_v;
      cand[4].out_byte     = st.held_b;
      cand[4].unit_kind    = (st.mode == abpse_pkg::MODE_PPS) ? abpse_pkg::KIND_PPS
                                                              : abpse_pkg::KIND_SPS;
      cand[4].unit_end     = 1'b1;
      cand[4].found_both   = 1'b0;
      cand_v[5]            = 1'b1;
      cand[5].out_byte     = 8'd0;
      cand[5].unit_kind    = abpse_pkg::KIND_STATUS;
      cand[5].unit_end     = 1'b0;
      cand[5].found_both   = st.sps && st.pps;
      st_d                 = ResetState;
      wv_d                 = 2'd0;
    end else begin
      st_d = st;
    end
  end

  // Pack the results of this byte into consecutive slots.
  always_comb begin
    n     = '0;
    set_o = '0;
    for (int j = 0; j < abpse_pkg::MaxResults; j++) begin
      if (cand_v[j]) begin
        for (int s = 0; s < abpse_pkg::MaxResults; s++) begin
          if (n == abpse_pkg::CntW'(s)) begin
            set_o.slot[s] = cand[j];
          end
        end
        n = n + 1'b1;
      end
    end
    set_o.cnt = fire ? n : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= ResetState;
      wv_q       <= 2'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        st_q <= st_d;
        wv_q <= wv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
      in_last_q <= in_last_i;
    end
    if (fire) begin
      win_q <= win_d;
    end
  end

endmodule

// ----- rtl/core/annexb_parameter_set_extractor.sv -----
// Channel   Direction  tdata           tuser                                  tlast
// s_axis    in         data_byte[7:0]  -                                      last_byte
// m_axis    out        out_byte[7:0]   unit_kind[1:0] found_both[2]           unit_end
//                                      run_last[3]
//
// One byte is taken per cycle while s_axis_tready is high; a taken byte is held in
// the input register and processed once the result buffer is free. Each byte yields
// zero or one result, except the final byte of a buffer, which yields up to six;
// those leave one per cycle from the result buffer while m_axis_tready is high.
// Reset clears all parsing state; after the final byte the state returns to reset.
// A stall on m_axis holds the result buffer and, once the input register is full,
// drops s_axis_tready.
module annexb_parameter_set_extractor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte[7:0]
  output logic [3:0] m_axis_tuser,   // unit_kind[1:0], found_both[2], run_last[3]
  output logic       m_axis_tlast
);

  abpse_pkg::res_set_t                  set;
  abpse_pkg::result_t [abpse_pkg::MaxResults-1:0] rs_q;
  logic [abpse_pkg::CntW-1:0]           cnt_q;
  logic [abpse_pkg::CntW-1:0]           k_q;
  abpse_pkg::result_t                   cur;
  logic                                 take;
  logic                                 at_last;
  logic                                 buf_free;

  abpse_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .buf_free_i (buf_free),
    .set_o      (set)
  );

  assign cur           = rs_q[k_q];
  assign at_last       = (k_q == cnt_q - 1'b1);
  assign m_axis_tvalid = (cnt_q != '0);
  assign take          = m_axis_tvalid && m_axis_tready;
  assign buf_free      = (cnt_q == '0) || (take && at_last);

  assign m_axis_tdata  = cur.out_byte;
  assign m_axis_tlast  = cur.unit_end;
  assign m_axis_tuser  = {at_last, cur.found_both, cur.unit_kind};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q   <= '0;
    end else if (set.cnt != '0) begin
      cnt_q <= set.cnt;
      k_q   <= '0;
    end else if (take && at_last) begin
      cnt_q <= '0;
      k_q   <= '0;
    end else if (take) begin
      k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set.cnt != '0) begin
      rs_q <= set.slot;
    end
  end

endmodule

// ----- rtl/core/abpse_checker.sv -----
`include "annexb_parameter_set_extractor_macros.svh"

module abpse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [3:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic        is_status;
  logic        stalled;
  logic        status_ok;
  logic [12:0] m_payload;

  assign is_status = m_axis_tuser[1:0] == abpse_pkg::KIND_STATUS;
  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign status_ok = m_axis_tuser[3] && !m_axis_tlast && (m_axis_tdata == 8'd0);
  assign m_payload = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // A status transaction closes the buffer, so nothing of that byte follows it.
  `ABPSE_ASSERT_SAME(a_status_closes, clk_i, rst_ni, m_axis_tvalid && is_status, status_ok)
  // The found flag belongs to status transactions only.
  `ABPSE_ASSERT_SAME(a_found_in_status, clk_i, rst_ni, m_axis_tvalid && !is_status, !m_axis_tuser[2])
  `ABPSE_ASSERT_SAME(a_kind_legal, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser[1:0] != 2'd3)
  `ABPSE_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, stalled, m_axis_tvalid)
  `ABPSE_ASSERT_NEXT(a_payload_holds, clk_i, rst_ni, stalled, $stable(m_payload))

endmodule

bind annexb_parameter_set_extractor abpse_checker u_abpse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
